FILE: hdl/bvg_pkg.sv
// Shared types and constants for the battery voltage gauge.
// Used by bvg_serial_div and battery_voltage_gauge; no dependencies.
package bvg_pkg;

    localparam int GROUP_SAMPLES = 32;
    localparam int COUNT_W       = 5;
    localparam int SUM_W         = 17;
    localparam int RAW_W         = 21;
    localparam int SMOOTH_W      = 22;
    localparam int ACC_W         = 31;
    localparam int NUM_W         = 30;
    localparam int DEN_W         = 23;
    localparam int QUOT_W        = 7;

    localparam logic [1:0] REG_MAX_MV  = 2'd0;
    localparam logic [1:0] REG_MIN_MV  = 2'd1;
    localparam logic [1:0] REG_ALPHA   = 2'd2;
    localparam logic [1:0] REG_HYST    = 2'd3;

    localparam logic [13:0] MAX_MV_RST = 14'd4200;
    localparam logic [13:0] MIN_MV_RST = 14'd3300;
    localparam logic [8:0]  ALPHA_RST  = 9'd26;
    localparam logic [6:0]  HYST_RST   = 7'd1;

    localparam logic [8:0]  ALPHA_FULL = 9'd256;
    localparam logic [6:0]  PCT_FULL   = 7'd100;
    localparam logic [6:0]  PCT_EMPTY  = 7'd0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_EMA,
        ST_LOAD,
        ST_PREP,
        ST_NUM,
        ST_DIV
    } gauge_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

FILE: hdl/bvg_serial_div.sv
// Restoring divider, one quotient bit per cycle, for the percent scaling.
// Depends on bvg_pkg for widths and the status struct.
module bvg_serial_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [bvg_pkg::NUM_W-1:0]     num,
    input  logic [bvg_pkg::DEN_W-1:0]     den,
    output logic [bvg_pkg::QUOT_W-1:0]    quot,
    output bvg_pkg::div_status_t          status
);
    import bvg_pkg::*;

    localparam logic [2:0] LAST_STEP = 3'(QUOT_W - 1);

    logic [NUM_W-1:0]  rem_reg;
    logic [NUM_W-1:0]  dsr_reg;
    logic [QUOT_W-1:0] quot_reg;
    logic [2:0]        step_reg;
    logic              busy_reg;
    logic              done_reg;
    logic              fits;

    assign fits = rem_reg >= dsr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + 3'd1;
                if (step_reg == LAST_STEP) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= num;
            dsr_reg  <= NUM_W'({den, LAST_STEP'(0), 3'b0} >> (3 - $bits(LAST_STEP) + 3));
            quot_reg <= '0;
        end else if (busy_reg) begin
            if (fits) begin
                rem_reg <= rem_reg - dsr_reg;
            end
            quot_reg <= {quot_reg[QUOT_W-2:0], fits};
            dsr_reg  <= dsr_reg >> 1;
        end
    end

    assign quot        = quot_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

FILE: hdl/battery_voltage_gauge.sv
// Battery voltage gauge: top level, APB register block, group accumulator,
// bit-serial EMA and percent control. Depends on bvg_pkg and bvg_serial_div.
//
// Samples are summed in groups of 32; one result beat leaves per group.
// A sample that does not close a group is taken while the FSM stays idle.
// A closing sample ends the group at once if the voltage clamps at max_mv.
// Otherwise it runs the shift-add for the EMA (one alpha bit a cycle) and a
// load step, both skipped for the first group, then the percent range
// check, which ends the group when the voltage sits at or outside the
// min_mv..max_mv window, and else a set-up step and the restoring divider
// (7 quotient bits and a done step). s_ready is low until the group ends,
// and a closing sample also waits while the previous result beat has not
// been taken.
module battery_voltage_gauge (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [11:0] s_sample_mv,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [13:0] m_voltage_mv,
    output logic [6:0]  m_percent,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import bvg_pkg::*;

    localparam logic [COUNT_W-1:0] GROUP_LAST = COUNT_W'(GROUP_SAMPLES - 1);
    localparam logic [3:0]         EMA_LAST   = 4'($bits(ALPHA_FULL) - 1);

    gauge_state_t state_reg, state_next;

    logic [13:0] max_reg, min_reg;
    logic [8:0]  alpha_reg;
    logic [6:0]  hyst_reg;

    logic [SUM_W-1:0]     sum_reg;
    logic [COUNT_W-1:0]   count_reg;
    logic [RAW_W-1:0]     raw_reg;
    logic [SMOOTH_W-1:0]  smoothed_reg;
    logic                 smoothed_valid_reg;
    logic [6:0]           shown_reg;
    logic                 shown_valid_reg;
    logic signed [ACC_W-1:0] acc_reg, dsh_reg;
    logic [8:0]           alpha_sh_reg;
    logic [3:0]           iter_reg;
    logic [SMOOTH_W-1:0]  pdiff_reg, dspan_reg;
    logic                 m_valid_reg;
    logic [13:0]          m_voltage_reg;
    logic [6:0]           m_percent_reg;

    logic                 s_fire, cfg_write, div_start, group_end;
    logic [SUM_W-1:0]     sum_new;
    logic [SMOOTH_W-1:0]  hi_q8, lo_q8;
    logic                 raw_clamp, at_hi, at_lo;
    logic signed [DEN_W-1:0] ema_diff;
    logic [NUM_W-1:0]     num;
    logic [QUOT_W-1:0]    quot;
    div_status_t          div_status;
    logic [6:0]           r_pct, pct_delta;
    logic                 take_r;

    assign s_fire    = s_valid && s_ready;
    assign cfg_write = psel && penable && pwrite && pready;
    assign group_end = count_reg == GROUP_LAST;
    assign sum_new   = sum_reg + SUM_W'(s_sample_mv);
    assign hi_q8     = {max_reg, 8'b0};
    assign lo_q8     = {min_reg, 8'b0};
    assign raw_clamp = {1'b0, raw_reg} >= hi_q8;
    assign at_hi     = smoothed_reg >= hi_q8;
    assign at_lo     = smoothed_reg <= lo_q8;
    assign ema_diff  = $signed({2'b0, raw_reg}) - $signed({1'b0, smoothed_reg});
    assign num       = NUM_W'({pdiff_reg, 7'b0}) + NUM_W'({pdiff_reg, 6'b0})
                     + NUM_W'({pdiff_reg, 3'b0}) + NUM_W'(dspan_reg);
    assign r_pct     = (quot > PCT_FULL) ? PCT_FULL : quot;
    assign pct_delta = (r_pct > shown_reg) ? r_pct - shown_reg : shown_reg - r_pct;
    assign take_r    = !shown_valid_reg || (pct_delta >= hyst_reg);

    bvg_serial_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (num),
        .den     ({dspan_reg, 1'b0}),
        .quot    (quot),
        .status  (div_status)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire && group_end) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (raw_clamp) begin
                    state_next = ST_IDLE;
                end else if (!smoothed_valid_reg) begin
                    state_next = ST_PREP;
                end else begin
                    state_next = ST_EMA;
                end
            end
            ST_EMA: begin
                if (iter_reg == EMA_LAST) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: state_next = ST_PREP;
            ST_PREP: begin
                if (at_hi || at_lo) begin
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_NUM;
                end
            end
            ST_NUM: state_next = ST_DIV;
            ST_DIV: begin
                if (div_status.done) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready   = 1'b0;
        div_start = 1'b0;
        case (state_reg)
            ST_IDLE: s_ready   = !group_end || !m_valid_reg;
            ST_NUM:  div_start = 1'b1;
            default: begin
                s_ready   = 1'b0;
                div_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= ST_IDLE;
            max_reg            <= MAX_MV_RST;
            min_reg            <= MIN_MV_RST;
            alpha_reg          <= ALPHA_RST;
            hyst_reg           <= HYST_RST;
            sum_reg            <= '0;
            count_reg          <= '0;
            smoothed_reg       <= '0;
            smoothed_valid_reg <= 1'b0;
            shown_reg          <= '0;
            shown_valid_reg    <= 1'b0;
            m_valid_reg        <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (cfg_write) begin
                case (paddr[3:2])
                    REG_MAX_MV: max_reg   <= pwdata[13:0];
                    REG_MIN_MV: min_reg   <= pwdata[13:0];
                    REG_ALPHA:  alpha_reg <= pwdata[8:0];
                    REG_HYST:   hyst_reg  <= pwdata[6:0];
                    default:    max_reg   <= max_reg;
                endcase
            end

            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end

            if (s_fire) begin
                if (group_end) begin
                    sum_reg   <= '0;
                    count_reg <= '0;
                end else begin
                    sum_reg   <= sum_new;
                    count_reg <= count_reg + COUNT_W'(1);
                end
            end

            case (state_reg)
                ST_CHECK: begin
                    if (raw_clamp) begin
                        m_valid_reg <= 1'b1;
                    end else if (!smoothed_valid_reg) begin
                        smoothed_reg       <= SMOOTH_W'(raw_reg);
                        smoothed_valid_reg <= 1'b1;
                    end
                end
                ST_LOAD: smoothed_reg <= acc_reg[SMOOTH_W+7:8];
                ST_PREP: begin
                    if (at_hi || at_lo) begin
                        m_valid_reg <= 1'b1;
                    end
                end
                ST_DIV: begin
                    if (div_status.done) begin
                        m_valid_reg <= 1'b1;
                        if (take_r) begin
                            shown_reg       <= r_pct;
                            shown_valid_reg <= 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire && group_end) begin
            raw_reg <= {sum_new, 4'b0};
        end
        case (state_reg)
            ST_CHECK: begin
                acc_reg      <= $signed({1'b0, smoothed_reg, 8'd128});
                dsh_reg      <= ACC_W'(ema_diff);
                alpha_sh_reg <= (alpha_reg > ALPHA_FULL) ? ALPHA_FULL : alpha_reg;
                iter_reg     <= '0;
                if (raw_clamp) begin
                    m_voltage_reg <= max_reg;
                    m_percent_reg <= PCT_FULL;
                end
            end
            ST_EMA: begin
                if (alpha_sh_reg[0]) begin
                    acc_reg <= acc_reg + dsh_reg;
                end
                dsh_reg      <= dsh_reg <<< 1;
                alpha_sh_reg <= alpha_sh_reg >> 1;
                iter_reg     <= iter_reg + 4'd1;
            end
            ST_PREP: begin
                m_voltage_reg <= smoothed_reg[SMOOTH_W-1:8];
                m_percent_reg <= at_hi ? PCT_FULL : PCT_EMPTY;
                pdiff_reg     <= smoothed_reg - lo_q8;
                dspan_reg     <= hi_q8 - lo_q8;
            end
            ST_DIV: begin
                if (div_status.done) begin
                    m_percent_reg <= take_r ? r_pct : shown_reg;
                end
            end
            default: iter_reg <= iter_reg;
        endcase
    end

    always_comb begin
        prdata = '0;
        case (paddr[3:2])
            REG_MAX_MV: prdata = 32'(max_reg);
            REG_MIN_MV: prdata = 32'(min_reg);
            REG_ALPHA:  prdata = 32'(alpha_reg);
            REG_HYST:   prdata = 32'(hyst_reg);
            default:    prdata = '0;
        endcase
    end

    assign pready       = 1'b1;
    assign m_valid      = m_valid_reg;
    assign m_voltage_mv = m_voltage_reg;
    assign m_percent    = m_percent_reg;

    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> state_reg == ST_IDLE)
        else $error("s_ready high outside idle");

    a_group_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && group_end) |=> (state_reg == ST_CHECK && count_reg == '0))
        else $error("group end did not start processing");

    a_pct_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> m_percent_reg <= PCT_FULL)
        else $error("percent out of range");

    a_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        div_status.busy |-> state_reg == ST_DIV)
        else $error("divider busy outside divide state");

endmodule
